[hdl/snd_pkg.sv]
package snd_pkg;

  // Offsets are carried in Q8.32 two's complement; the true values stay well inside.
  localparam int unsigned DW    = 40;
  // Corner offsets in Q.30.
  localparam int unsigned QW    = 32;
  localparam int unsigned DOTW  = 34;
  localparam int unsigned TERMW = 32;
  localparam int unsigned SUMW  = 34;

  localparam logic [31:0] SKEW_K   = 32'd1572067139;
  localparam logic [29:0] UNSKEW_K = 30'd907633386;
  localparam logic [59:0] HALF_Q60 = 60'h800000000000000;

  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] val;
  } perm_wr_t;

  // Remainder by twelve of an 8-bit value, by reciprocal multiply.
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd171;
    q = p[15:11];
    r = v - 8'({3'b000, q} * 8'd12);
    return r[3:0];
  endfunction

  function automatic logic signed [1:0] grad_x(input logic [3:0] g);
    logic signed [1:0] r;
    unique case (g)
      4'd0, 4'd2, 4'd4, 4'd6: r = 2'sd1;
      4'd1, 4'd3, 4'd5, 4'd7: r = -2'sd1;
      default:                r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] grad_y(input logic [3:0] g);
    logic signed [1:0] r;
    unique case (g)
      4'd0, 4'd1, 4'd8, 4'd10: r = 2'sd1;
      4'd2, 4'd3, 4'd9, 4'd11: r = -2'sd1;
      default:                 r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/snd_perm_ram.sv]
module snd_perm_ram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [7:0]         rd_addr_a_i,
  input  logic [7:0]         rd_addr_b_i,
  input  snd_pkg::perm_wr_t  wr_i,
  output logic [7:0]         rd_data_a_o,
  output logic [7:0]         rd_data_b_o
);
  import snd_pkg::*;

  logic [7:0]   mem_q [256];
  logic [255:0] vld_q;
  logic [7:0]   rd_a_q, rd_b_q;

  // Entries never written read as their own index.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= vld_q[rd_addr_a_i] ? mem_q[rd_addr_a_i] : rd_addr_a_i;
      rd_b_q <= vld_q[rd_addr_b_i] ? mem_q[rd_addr_b_i] : rd_addr_b_i;
    end
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[hdl/snd_skew.sv]
module snd_skew #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned CsW = 34 - FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [31:0]            x_i,
  input  logic signed [31:0]            y_i,
  output logic [7:0]                    cj_lo_o,
  output logic [7:0]                    ci_lo_o,
  output logic signed [CsW-1:0]         cs_o,
  output logic signed [snd_pkg::DW-1:0] bx_o,
  output logic signed [snd_pkg::DW-1:0] by_o
);
  import snd_pkg::*;

  localparam int unsigned CW = CsW - 1;
  localparam int unsigned SH = 32 - FRAC_BITS;

  logic signed [31:0]     x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic signed [32:0]     sxy_q;
  logic signed [63:0]     prod_q;
  logic signed [CW-1:0]   ci3_q, cj3_q;
  logic signed [CsW-1:0]  cs_q;
  logic signed [DW-1:0]   bx_q, by_q;
  logic [7:0]             ci_lo_q;

  logic signed [31:0]     skew;
  logic signed [32:0]     xs, ys;
  logic signed [DW-1:0]   xe, ye;

  always_comb begin
    skew = prod_q[63:32];
    xs   = 33'(x2_q) + 33'(skew);
    ys   = 33'(y2_q) + 33'(skew);
    xe   = DW'(x3_q) <<< SH;
    ye   = DW'(y3_q) <<< SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x_i;
      y1_q    <= y_i;
      sxy_q   <= 33'(x_i) + 33'(y_i);
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      prod_q  <= sxy_q * $signed({1'b0, SKEW_K});
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      ci3_q   <= xs[32:FRAC_BITS];
      cj3_q   <= ys[32:FRAC_BITS];
      cs_q    <= CsW'(ci3_q) + CsW'(cj3_q);
      bx_q    <= xe - {ci3_q[7:0], {(DW - 8){1'b0}}};
      by_q    <= ye - {cj3_q[7:0], {(DW - 8){1'b0}}};
      ci_lo_q <= ci3_q[7:0];
    end
  end

  assign cj_lo_o = cj3_q[7:0];
  assign ci_lo_o = ci_lo_q;
  assign cs_o    = cs_q;
  assign bx_o    = bx_q;
  assign by_o    = by_q;

endmodule

[hdl/snd_corner.sv]
module snd_corner (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [snd_pkg::QW-1:0]    dx_i,
  input  logic signed [snd_pkg::QW-1:0]    dy_i,
  input  logic [3:0]                       grad_i,
  output logic signed [snd_pkg::TERMW-1:0] term_o
);
  import snd_pkg::*;

  logic [62:0]             sqx_q, sqy_q;
  logic signed [DOTW-1:0]  dot_a_q, dot_b_q, dot_c_q, dot_d_q;
  logic [29:0]             t30_q;
  logic [28:0]             t2_q;
  logic [26:0]             t4_q;
  logic signed [TERMW-1:0] term_q;

  logic signed [63:0]      px, py;
  logic signed [1:0]       gx, gy;
  logic signed [DOTW-1:0]  dxe, dye, dot;
  logic signed [64:0]      t_full;
  logic [59:0]             p2;
  logic [57:0]             p4;
  logic signed [61:0]      pt;

  always_comb begin
    px     = 64'(dx_i) * 64'(dx_i);
    py     = 64'(dy_i) * 64'(dy_i);
    gx     = grad_x(grad_i);
    gy     = grad_y(grad_i);
    dxe    = DOTW'(dx_i);
    dye    = DOTW'(dy_i);
    dot    = (gx == 2'sd1 ? dxe : (gx == -2'sd1 ? -dxe : '0))
           + (gy == 2'sd1 ? dye : (gy == -2'sd1 ? -dye : '0));
    t_full = $signed({5'b00000, HALF_Q60}) - $signed({2'b00, sqx_q})
           - $signed({2'b00, sqy_q});
    p2     = 60'(t30_q) * 60'(t30_q);
    p4     = 58'(t2_q) * 58'(t2_q);
    pt     = 62'($signed({1'b0, t4_q})) * 62'(dot_d_q);
  end

  // A corner outside the kernel radius gets t = 0, which zeroes its term.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= px[62:0];
      sqy_q   <= py[62:0];
      dot_a_q <= dot;
      t30_q   <= t_full[64] ? '0 : t_full[59:30];
      dot_b_q <= dot_a_q;
      t2_q    <= p2[58:30];
      dot_c_q <= dot_b_q;
      t4_q    <= p4[56:30];
      dot_d_q <= dot_c_q;
      term_q  <= pt[61:30];
    end
  end

  assign term_o = term_q;

endmodule

[hdl/simplex_noise_2d.sv]
// 2D simplex noise on a stream of Q16.16 points, one result in Q1.15 per point.
// Input channel: in_valid_i / in_stall_o with cmd_i, x_coord_i, y_coord_i,
// entry_index_i and entry_value_i. A transaction with cmd_i low evaluates noise
// at the point; with cmd_i high it loads one entry of the permutation table and
// produces no result. Output channel: out_valid_o / out_stall_i with
// noise_value_o. Results leave in the order their points were accepted.
// Throughput is one transaction per cycle while the receiver does not stall.
// Every multiplier sits in its own pipeline stage, and the permutation table is
// kept in three identical two-port copies so that the six lookups of a point
// are all served each cycle. A table write takes effect for every point
// accepted after it. Reset clears all valid bits and returns the table to
// identity at once; no clearing pass is needed. When the receiver stalls a
// waiting result, the whole pipeline holds and in_stall_o is raised; nothing
// is lost or repeated.
module simplex_noise_2d #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         entry_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] noise_value_o
);
  import snd_pkg::*;

  localparam int unsigned CsW = 34 - FRAC_BITS;

  // The pipeline advances unless a finished result is held by the receiver.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits for evaluations, one per stage, and a short lane for writes.
  logic [12:0]      ev_q;
  logic [2:0]       wv_q;
  logic [2:0][7:0]  widx_q, wval_q;
  logic             out_valid_q;
  logic signed [15:0] noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q        <= '0;
      wv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ev_q        <= {ev_q[11:0], in_valid_i && (cmd_i != CMD_WRITE)};
      wv_q        <= {wv_q[1:0], in_valid_i && (cmd_i == CMD_WRITE)};
      out_valid_q <= ev_q[12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      widx_q <= {widx_q[1:0], entry_index_i};
      wval_q <= {wval_q[1:0], entry_value_i};
    end
  end

  // Skew, cell and base offsets (stages one to four).
  logic [7:0]            cj_lo, ci_lo;
  logic signed [CsW-1:0] cs;
  logic signed [DW-1:0]  bx, by;

  snd_skew #(.FRAC_BITS(FRAC_BITS)) u_skew (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x_coord_i),
    .y_i     (y_coord_i),
    .cj_lo_o (cj_lo),
    .ci_lo_o (ci_lo),
    .cs_o    (cs),
    .bx_o    (bx),
    .by_o    (by)
  );

  // A write lands when it reaches stage three: the point ahead of it reads
  // the old entry in its last lookup, and the point behind has made none yet.
  perm_wr_t pw;
  always_comb begin
    pw.en  = en && wv_q[2];
    pw.idx = widx_q[2];
    pw.val = wval_q[2];
  end

  // First lookup: perm[j] and perm[j+1]. Second lookup: all four candidates
  // perm[i + perm[..]], so the triangle choice is only needed afterwards.
  logic [7:0] pj0, pj1, r0, r1a, r1b, r2;

  snd_perm_ram u_perm_j (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (en),
    .rd_addr_a_i (cj_lo),
    .rd_addr_b_i (cj_lo + 8'd1),
    .wr_i        (pw),
    .rd_data_a_o (pj0),
    .rd_data_b_o (pj1)
  );

  snd_perm_ram u_perm_ia (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (en),
    .rd_addr_a_i (ci_lo + pj0),
    .rd_addr_b_i (ci_lo + 8'd1 + pj1),
    .wr_i        (pw),
    .rd_data_a_o (r0),
    .rd_data_b_o (r2)
  );

  snd_perm_ram u_perm_ib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (en),
    .rd_addr_a_i (ci_lo + 8'd1 + pj0),
    .rd_addr_b_i (ci_lo + pj1),
    .wr_i        (pw),
    .rd_data_a_o (r1a),
    .rd_data_b_o (r1b)
  );

  // Stage five: unskew product. Stage six: first-corner offset and gradient
  // indices. Stage seven: triangle choice and all three corner offsets in Q.30.
  logic signed [CsW+30:0] uprod;
  logic signed [DW-1:0]   unsk_q, bx5_q, by5_q, d0x_q, d0y_q;
  logic [3:0]             g0_q, g1a_q, g1b_q, g2_q;
  logic signed [QW-1:0]   dx_q [3];
  logic signed [QW-1:0]   dy_q [3];
  logic [3:0]             gs_q [3];

  localparam logic signed [DW-1:0] ONE_Q32 = DW'(64'h1_0000_0000);
  localparam logic signed [DW-1:0] G2_Q32  = DW'(UNSKEW_K);

  logic                 ox;
  logic signed [DW-1:0] d1x, d1y, d2x, d2y;

  always_comb begin
    uprod = cs * $signed({1'b0, UNSKEW_K});
    // On a tie the upper triangle is taken.
    ox  = d0x_q > d0y_q;
    d1x = d0x_q - (ox ? ONE_Q32 : '0) + G2_Q32;
    d1y = d0y_q - (ox ? '0 : ONE_Q32) + G2_Q32;
    d2x = d0x_q - ONE_Q32 + G2_Q32 + G2_Q32;
    d2y = d0y_q - ONE_Q32 + G2_Q32 + G2_Q32;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unsk_q   <= uprod[DW-1:0];
      bx5_q    <= bx;
      by5_q    <= by;
      d0x_q    <= bx5_q + unsk_q;
      d0y_q    <= by5_q + unsk_q;
      g0_q     <= mod12(r0);
      g1a_q    <= mod12(r1a);
      g1b_q    <= mod12(r1b);
      g2_q     <= mod12(r2);
      dx_q[0]  <= d0x_q[QW+1:2];
      dy_q[0]  <= d0y_q[QW+1:2];
      dx_q[1]  <= d1x[QW+1:2];
      dy_q[1]  <= d1y[QW+1:2];
      dx_q[2]  <= d2x[QW+1:2];
      dy_q[2]  <= d2y[QW+1:2];
      gs_q[0]  <= g0_q;
      gs_q[1]  <= ox ? g1a_q : g1b_q;
      gs_q[2]  <= g2_q;
    end
  end

  // Stages eight to twelve: one falloff-and-dot pipeline per corner.
  logic signed [TERMW-1:0] term [3];

  for (genvar k = 0; k < 3; k++) begin : g_corner
    snd_corner u_corner (
      .clk_i  (clk_i),
      .en_i   (en),
      .dx_i   (dx_q[k]),
      .dy_i   (dy_q[k]),
      .grad_i (gs_q[k]),
      .term_o (term[k])
    );
  end

  // Stage thirteen: corner sum. Stage fourteen: scale by 70, floor to Q1.15
  // and saturate into the output register.
  logic signed [SUMW-1:0] sum_q;
  logic signed [40:0]     p70;
  logic signed [25:0]     res;
  logic signed [15:0]     sat;

  always_comb begin
    p70 = 41'(sum_q) * 41'sd70;
    res = p70[40:15];
    if (res > 26'sd32767) begin
      sat = 16'sh7fff;
    end else if (res < -26'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = res[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= SUMW'(term[0]) + SUMW'(term[1]) + SUMW'(term[2]);
      noise_q <= sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  // A table write never turns into a result.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i == CMD_WRITE) |=> !ev_q[0])
    else $error("write transaction entered the evaluation pipeline");

  // A stall freezes every stage and keeps the waiting result on the port.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(ev_q) && $stable(wv_q) && out_valid_o))
    else $error("pipeline moved during a stall");

  // A point in the last stage reaches the output register on the next edge.
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && ev_q[12]) |=> out_valid_o)
    else $error("result dropped before the output register");

endmodule
